>>> hdl/kprs_pkg.sv
// Package for the key/payload record sorter: sizes, channel beat types and
// the queue entry passed from the front end to the sort array. No dependencies.
package kprs_pkg;

	// Sort array capacity and the payload bits kept per record
	localparam int MAX_RECORDS   = 64;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int KEY_W         = 32;
	localparam int PORT_PAY_W    = 32;
	localparam int PAY_W         = (PAYLOAD_WIDTH < PORT_PAY_W) ? PAYLOAD_WIDTH : PORT_PAY_W;
	localparam int CNT_W         = $clog2(MAX_RECORDS + 1);

	// Decoupling queue between front end and sort array
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [KEY_W-1:0]      record_key;
		logic [PORT_PAY_W-1:0] record_payload;
		logic                  last_item;
	} record_t;

	typedef struct packed {
		logic [KEY_W-1:0]      sorted_key;
		logic [PORT_PAY_W-1:0] sorted_payload;
		logic                  last_out;
		logic                  records_dropped;
	} result_t;

	// Classified record: store it or discard it, and whether it closes the set
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic             store;
		logic             last;
		logic             dropped;
	} qent_t;

endpackage

>>> hdl/kprs_fifo.sv
// Small register queue of classified records between front end and sort array.
// Depends on kprs_pkg for the entry type and depth.
module kprs_fifo
	import kprs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	output logic  full,
	input  logic  pop,
	output qent_t pop_data,
	output logic  empty
);

	qent_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W:0]   wr_ptr_q;
	logic [QPTR_W:0]   rd_ptr_q;

	assign empty    = (wr_ptr_q == rd_ptr_q);
	assign full     = (wr_ptr_q[QPTR_W] != rd_ptr_q[QPTR_W]) &&
	                  (wr_ptr_q[QPTR_W-1:0] == rd_ptr_q[QPTR_W-1:0]);
	assign pop_data = mem_q[rd_ptr_q[QPTR_W-1:0]];

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	// Write entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q[QPTR_W-1:0]] <= push_data;
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue read while empty");
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> full) else $error("full queue lost an entry without a pop");

endmodule

>>> hdl/kprs_front.sv
// Front end: accepts record beats, decides store or discard against capacity,
// and pushes the classified record into the queue. Depends on kprs_pkg.
module kprs_front
	import kprs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    record_valid,
	output logic    record_stall,
	input  record_t record,
	output logic    push,
	output qent_t   push_data,
	input  logic    queue_full
);

	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic             room;

	assign record_stall = queue_full;
	assign push         = record_valid && !queue_full;
	assign room         = (count_q < CNT_W'(MAX_RECORDS));

	// Classify the incoming record
	always_comb begin
		push_data.key     = record.record_key;
		push_data.payload = record.record_payload[PAY_W-1:0];
		push_data.store   = room;
		push_data.last    = record.last_item;
		push_data.dropped = overflow_q || !room;
	end

	// Track set fill level; clear on the closing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (push) begin
			if (record.last_item) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (room) begin
				count_q <= count_q + 1'b1;
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECORDS)) else $error("set count beyond capacity");
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> !room) else $error("overflow flagged with room left");
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && record.last_item |=> count_q == '0 && !overflow_q)
		else $error("set state not cleared after closing beat");

endmodule

>>> hdl/kprs_sort_array.sv
// Back end: a row of insertion cells kept in ascending key order. Records are
// inserted one per cycle from the queue, then drained from cell 0. Depends on kprs_pkg.
module kprs_sort_array
	import kprs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    queue_empty,
	input  qent_t   entry,
	output logic    pop,
	output logic    sorted_valid,
	input  logic    sorted_stall,
	output result_t sorted
);

	typedef enum logic {LOAD, DRAIN} state_t;

	state_t                 state_q;
	logic                   drop_q;
	logic [MAX_RECORDS-1:0] valid_q;
	logic [KEY_W-1:0]       key_q [MAX_RECORDS];
	logic [PAY_W-1:0]       pay_q [MAX_RECORDS];

	logic [MAX_RECORDS-1:0] gt;
	logic [MAX_RECORDS-1:0] prev_gt;
	logic [MAX_RECORDS-1:0] prev_valid;
	logic [MAX_RECORDS-1:0] ins;
	logic [KEY_W-1:0]       key_up [MAX_RECORDS];
	logic [PAY_W-1:0]       pay_up [MAX_RECORDS];
	logic [KEY_W-1:0]       key_dn [MAX_RECORDS];
	logic [PAY_W-1:0]       pay_dn [MAX_RECORDS];
	logic                   load_en;
	logic                   drain_en;

	assign pop      = (state_q == LOAD) && !queue_empty;
	assign load_en  = pop && entry.store;
	assign sorted_valid = (state_q == DRAIN) && valid_q[0];
	assign drain_en = sorted_valid && !sorted_stall;

	// Drive the result beat straight from the head cell
	always_comb begin
		sorted.sorted_key      = key_q[0];
		sorted.sorted_payload  = PORT_PAY_W'(pay_q[0]);
		sorted.last_out        = !valid_q[1];
		sorted.records_dropped = drop_q;
	end

	// Compare every cell with the incoming key; find the insertion point
	always_comb begin
		for (int i = 0; i < MAX_RECORDS; i++) begin
			gt[i] = valid_q[i] && (key_q[i] > entry.key);
		end
		prev_gt    = {gt[MAX_RECORDS-2:0], 1'b0};
		prev_valid = {valid_q[MAX_RECORDS-2:0], 1'b1};
		ins        = prev_valid & ~prev_gt & (gt | ~valid_q);
	end

	// Neighbor taps for shifting up on insert and down on drain
	always_comb begin
		key_up[0] = entry.key;
		pay_up[0] = entry.payload;
		key_dn[MAX_RECORDS-1] = key_q[MAX_RECORDS-1];
		pay_dn[MAX_RECORDS-1] = pay_q[MAX_RECORDS-1];
		for (int i = 1; i < MAX_RECORDS; i++) begin
			key_up[i]   = key_q[i-1];
			pay_up[i]   = pay_q[i-1];
			key_dn[i-1] = key_q[i];
			pay_dn[i-1] = pay_q[i];
		end
	end

	// Cell contents: shift up past the insertion point, or shift down on drain
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RECORDS; i++) begin
			if (load_en) begin
				if (prev_gt[i]) begin
					key_q[i] <= key_up[i];
					pay_q[i] <= pay_up[i];
				end else if (ins[i]) begin
					key_q[i] <= entry.key;
					pay_q[i] <= entry.payload;
				end
			end else if (drain_en) begin
				key_q[i] <= key_dn[i];
				pay_q[i] <= pay_dn[i];
			end
		end
	end

	// Sequence load and drain; hold occupancy and the drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			drop_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			unique case (state_q)
				LOAD: begin
					if (load_en) valid_q <= valid_q | ins | prev_gt;
					if (pop && entry.last) begin
						state_q <= DRAIN;
						drop_q  <= entry.dropped;
					end
				end
				DRAIN: begin
					if (drain_en) begin
						valid_q <= {1'b0, valid_q[MAX_RECORDS-1:1]};
						if (!valid_q[1]) state_q <= LOAD;
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[MAX_RECORDS-1:1] & ~valid_q[MAX_RECORDS-2:0]) == '0)
		else $error("occupied cells not contiguous from the head");
	a_store_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		load_en |-> !valid_q[MAX_RECORDS-1]) else $error("insert into a full array");
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DRAIN |-> valid_q[0]) else $error("drain with no record held");
	a_head_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[1] |-> key_q[0] <= key_q[1]) else $error("head cells out of order");

endmodule

>>> hdl/key_payload_record_sorter_unit.sv
// Top level of the key/payload record sorter: front end, decoupling queue
// and sort array. Depends on kprs_pkg, kprs_front, kprs_fifo, kprs_sort_array.
//
// Usage:
//   record channel (record_valid / record_stall / record): one record per beat.
//   A beat with last_item set closes the set and starts the sorted run.
//   sorted channel (sorted_valid / sorted_stall / sorted): one beat per held
//   record in ascending unsigned key order, equal keys in arrival order,
//   last_out on the final beat, records_dropped on every beat of a run whose
//   set exceeded MAX_RECORDS (the excess records are discarded).
// Timing:
//   Records enter at one per cycle while record_stall is low, and are inserted
//   into the cell row from the queue. The first result is offered the cycle
//   after the closing record is inserted, which follows its queue write;
//   then one result per cycle while sorted_stall is low. Insert and drain
//   share the single insert/drain port of the cell row, so a set drains
//   before the next set is inserted. The next set's records are taken into
//   the 4-entry queue during a drain, after which record_stall rises until the drain finishes.
// Reset: arst_n clears the queue, set counters and cell occupancy; the row
//   needs no clearing pass. A stall on the sorted channel holds the current
//   beat unchanged.
module key_payload_record_sorter_unit
	import kprs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    record_valid,
	output logic    record_stall,
	input  record_t record,
	output logic    sorted_valid,
	input  logic    sorted_stall,
	output result_t sorted
);

	logic  push;
	qent_t push_data;
	logic  queue_full;
	logic  pop;
	qent_t pop_data;
	logic  queue_empty;

	kprs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.record_valid (record_valid),
		.record_stall (record_stall),
		.record       (record),
		.push         (push),
		.push_data    (push_data),
		.queue_full   (queue_full)
	);

	kprs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (queue_empty)
	);

	kprs_sort_array u_sort (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.entry        (pop_data),
		.pop          (pop),
		.sorted_valid (sorted_valid),
		.sorted_stall (sorted_stall),
		.sorted       (sorted)
	);

endmodule

>>> tb/testbench.sv
// Self-checking testbench for key_payload_record_sorter_unit: streams record sets
// and checks each sorted beat against an in-bench stable sort of the same set.
// Depends on kprs_pkg and the sorter RTL only.
`timescale 1ns / 100ps

module testbench;
	import kprs_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 6;
	localparam int MAX_GAP      = 17;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 40;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 40;
	localparam logic [PORT_PAY_W-1:0] PAY_KEEP = {PORT_PAY_W{1'b1}} >> (PORT_PAY_W - PAY_W);

	typedef enum int {KEYS_WIDE, KEYS_CROWDED, KEYS_EDGES, KEYS_MIDPOINT} key_style_t;

	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic [PORT_PAY_W-1:0] pay;
	} held_rec_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    record_valid;
	logic    record_stall;
	record_t record;
	logic    sorted_valid;
	logic    sorted_stall;
	result_t sorted;

	// Model state: records of the open set and the sorted beats still owed
	held_rec_t held_set[$];
	logic      held_overflow = 1'b0;
	result_t   pending_sorted[$];

	// Idling controls shared by the sender, the receiver, the monitor and the tests
	bit send_gaps     = 1'b1;
	bit sink_gaps     = 1'b1;
	bit long_hold_req = 1'b0;
	bit beat_taken    = 1'b0;

	int fail_count      = 0;
	int records_taken   = 0;
	int beats_checked   = 0;
	int sets_closed     = 0;
	int sets_overflowed = 0;

	key_payload_record_sorter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.record_valid (record_valid),
		.record_stall (record_stall),
		.record       (record),
		.sorted_valid (sorted_valid),
		.sorted_stall (sorted_stall),
		.sorted       (sorted)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int draw_gap(bit enabled);
		if (!enabled)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(key_style_t style);
		case (style)
			KEYS_CROWDED:  return $urandom_range(0, 7);
			KEYS_EDGES:    return $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 3))
			                                            : ~KEY_W'($urandom_range(0, 3));
			KEYS_MIDPOINT: return 32'h8000_0000 ^ (32'h8000_0003 & $urandom());
			default:       return $urandom();
		endcase
	endfunction

	// Close the set: stable insertion by unsigned key, then queue one beat per record
	function automatic void close_set();
		held_rec_t run[$];
		held_rec_t rec;
		result_t   beat;
		int        j;
		foreach (held_set[i]) begin
			rec = held_set[i];
			j = run.size();
			while (j > 0 && run[j-1].key > rec.key)
				j--;
			run.insert(j, rec);
		end
		foreach (run[i]) begin
			beat.sorted_key      = run[i].key;
			beat.sorted_payload  = run[i].pay;
			beat.last_out        = (i == run.size() - 1);
			beat.records_dropped = held_overflow;
			pending_sorted.push_back(beat);
		end
		sets_closed++;
		if (held_overflow)
			sets_overflowed++;
		held_set.delete();
		held_overflow = 1'b0;
	endfunction

	// Store the record while there is room, else flag the drop
	function automatic void absorb_record(record_t rec);
		held_rec_t entry;
		if (held_set.size() < MAX_RECORDS) begin
			entry.key = rec.record_key;
			entry.pay = rec.record_payload & PAY_KEEP;
			held_set.push_back(entry);
		end else begin
			held_overflow = 1'b1;
		end
		if (rec.last_item)
			close_set();
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// Sample both channels mid-cycle: a beat seen here is taken at the next rising edge
	always @(negedge clk) begin : beat_monitor
		result_t want;
		beat_taken = 1'b0;
		if (arst_n === 1'b1) begin
			if (record_valid && record_stall === 1'b0) begin
				absorb_record(record);
				records_taken++;
			end
			if (sorted_valid === 1'b1 && !sorted_stall) begin
				beat_taken = 1'b1;
				beats_checked++;
				if (pending_sorted.size() == 0) begin
					$display("%0t: sorted beat with nothing expected: key %h payload %h",
						$time, sorted.sorted_key, sorted.sorted_payload);
					fail_count++;
				end else begin
					want = pending_sorted.pop_front();
					check_field("sorted_key", want.sorted_key, sorted.sorted_key);
					check_field("sorted_payload", want.sorted_payload, sorted.sorted_payload);
					check_field("last_out", want.last_out, sorted.last_out);
					check_field("records_dropped", want.records_dropped, sorted.records_dropped);
				end
			end
		end
	end

	// Receiver: random stall after each beat, plus one long hold on request
	initial begin : sorted_sink
		int wait_left;
		int hold_left;
		wait_left = 0;
		hold_left = 0;
		sorted_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				sorted_stall <= 1'b1;
			end else begin
				if (beat_taken)
					wait_left = draw_gap(sink_gaps);
				if (wait_left > 0) begin
					wait_left--;
					sorted_stall <= 1'b1;
				end else begin
					sorted_stall <= 1'b0;
				end
			end
		end
	end

	// Offer one record beat; entered and left just after a rising edge
	task automatic send_record(input logic [KEY_W-1:0] key, input logic [PORT_PAY_W-1:0] pay,
			input logic last);
		int  gap;
		bit  taken;
		gap = draw_gap(send_gaps);
		if (gap > 0) begin
			record_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		record_valid <= 1'b1;
		record <= '{record_key: key, record_payload: pay, last_item: last};
		do begin
			@(negedge clk);
			taken = (record_stall === 1'b0);
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_set(input int count, input key_style_t style);
		for (int i = 0; i < count; i++)
			send_record(pick_key(style), $urandom(), i == count - 1);
	endtask

	task automatic test_directed_edges();
		send_gaps = 1'b1;
		sink_gaps = 1'b1;
		// lone record is a whole set
		send_record(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
		// keys far apart across the sign boundary still sort unsigned
		send_record(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		send_record(32'h8000_0000, 32'hAAAA_5555, 1'b0);
		send_record(32'h0000_0000, 32'h5555_AAAA, 1'b0);
		send_record(32'h7FFF_FFFF, 32'h8000_0001, 1'b0);
		send_record(32'h0000_0001, 32'h7FFF_FFFE, 1'b0);
		send_record(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);
		// equal keys leave in arrival order
		send_record(32'd5, 32'd1, 1'b0);
		send_record(32'd3, 32'd2, 1'b0);
		send_record(32'd5, 32'd3, 1'b0);
		send_record(32'd3, 32'd4, 1'b0);
		send_record(32'd5, 32'd5, 1'b1);
		// descending, then already ascending
		for (int i = 0; i < 4; i++)
			send_record(32'd40 - 32'(i * 10), 32'(i), i == 3);
		for (int i = 0; i < 4; i++)
			send_record(32'(i * 10), 32'(i), i == 3);
	endtask

	task automatic test_capacity();
		// closing beat lands after the store is full: dropped, yet it ends the set
		send_set(MAX_RECORDS + 2, KEYS_CROWDED);
		// next set must come out clean
		send_set(2, KEYS_EDGES);
	endtask

	task automatic test_backpressure();
		send_gaps = 1'b0;
		long_hold_req = 1'b1;
		send_set(12, KEYS_WIDE);
		send_set(10, KEYS_MIDPOINT);
		send_gaps = 1'b1;
	endtask

	task automatic test_random_sets();
		int         sent;
		int         count;
		int         roll;
		key_style_t style;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 75)
				count = $urandom_range(1, 8);
			else if (roll < 93)
				count = $urandom_range(9, 32);
			else if (roll < 98)
				count = $urandom_range(33, MAX_RECORDS);
			else
				count = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
			style = key_style_t'($urandom_range(0, 3));
			send_gaps = ($urandom_range(0, 3) != 0);
			sink_gaps = ($urandom_range(0, 3) != 0);
			send_set(count, style);
			sent += count;
		end
	endtask

	initial begin : run_tests
		int spin;
		arst_n       <= 1'b0;
		record_valid <= 1'b0;
		record       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_capacity();
		test_backpressure();
		test_random_sets();
		record_valid <= 1'b0;
		sink_gaps = 1'b1;

		// wait out the last drain, then watch for stray beats
		spin = 0;
		while (pending_sorted.size() != 0 && spin < DRAIN_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_sorted.size() != 0) begin
			$display("%0t: %0d sorted beats never arrived, next expected key %h",
				$time, pending_sorted.size(), pending_sorted[0].sorted_key);
			fail_count++;
		end

		$display("Sorted %0d record sets from %0d records, %0d of them over capacity;",
			sets_closed, records_taken, sets_overflowed);
		$display("checked %0d output beats with random stalls on both sides.", beats_checked);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
